[hdl/eight_bit_cpu_instruction_step_defines.svh]
// Assertion macros used by the CPU step RTL file.
`ifndef EIGHT_BIT_CPU_INSTRUCTION_STEP_DEFINES_SVH
`define EIGHT_BIT_CPU_INSTRUCTION_STEP_DEFINES_SVH

// Assert an implication on every rising clock edge outside reset.
`define ECPU_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Assert an implication whose consequent is checked in the cycle after the antecedent.
`define ECPU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ecpu_pkg.sv]
// ----------------------------------------------------------------------------
// ecpu_pkg
// Shared types and constants of the 8-bit CPU step block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ecpu_pkg;

    localparam int ADDR_BITS_DEF = 16;

    localparam logic [4:0] F_CY = 5'h01;
    localparam logic [4:0] F_P  = 5'h02;
    localparam logic [4:0] F_AC = 5'h04;
    localparam logic [4:0] F_Z  = 5'h08;
    localparam logic [4:0] F_S  = 5'h10;

    localparam logic [7:0] OP_NOP      = 8'h00;
    localparam logic [7:0] OP_LXI_B    = 8'h01;
    localparam logic [7:0] OP_DCR_B    = 8'h05;
    localparam logic [7:0] OP_MVI_B    = 8'h06;
    localparam logic [7:0] OP_DAD_B    = 8'h09;
    localparam logic [7:0] OP_DCR_C    = 8'h0D;
    localparam logic [7:0] OP_MVI_C    = 8'h0E;
    localparam logic [7:0] OP_RRC      = 8'h0F;
    localparam logic [7:0] OP_LXI_D    = 8'h11;
    localparam logic [7:0] OP_INX_D    = 8'h13;
    localparam logic [7:0] OP_DAD_D    = 8'h19;
    localparam logic [7:0] OP_LDAX_D   = 8'h1A;
    localparam logic [7:0] OP_RAR      = 8'h1F;
    localparam logic [7:0] OP_LXI_H    = 8'h21;
    localparam logic [7:0] OP_INX_H    = 8'h23;
    localparam logic [7:0] OP_MVI_H    = 8'h26;
    localparam logic [7:0] OP_DAD_H    = 8'h29;
    localparam logic [7:0] OP_CMA      = 8'h2F;
    localparam logic [7:0] OP_LXI_SP   = 8'h31;
    localparam logic [7:0] OP_STA      = 8'h32;
    localparam logic [7:0] OP_MVI_M    = 8'h36;
    localparam logic [7:0] OP_LDA      = 8'h3A;
    localparam logic [7:0] OP_MVI_A    = 8'h3E;
    localparam logic [7:0] OP_MOV_BC   = 8'h41;
    localparam logic [7:0] OP_MOV_BD   = 8'h42;
    localparam logic [7:0] OP_MOV_BE   = 8'h43;
    localparam logic [7:0] OP_MOV_DM   = 8'h56;
    localparam logic [7:0] OP_MOV_EM   = 8'h5E;
    localparam logic [7:0] OP_MOV_HM   = 8'h66;
    localparam logic [7:0] OP_MOV_LA   = 8'h6F;
    localparam logic [7:0] OP_MOV_MA   = 8'h77;
    localparam logic [7:0] OP_MOV_AD   = 8'h7A;
    localparam logic [7:0] OP_MOV_AE   = 8'h7B;
    localparam logic [7:0] OP_MOV_AH   = 8'h7C;
    localparam logic [7:0] OP_MOV_AM   = 8'h7E;
    localparam logic [7:0] OP_ADD_B    = 8'h80;
    localparam logic [7:0] OP_ADD_C    = 8'h81;
    localparam logic [7:0] OP_ADD_M    = 8'h86;
    localparam logic [7:0] OP_ANA_A    = 8'hA7;
    localparam logic [7:0] OP_XRA_A    = 8'hAF;
    localparam logic [7:0] OP_POP_B    = 8'hC1;
    localparam logic [7:0] OP_JNZ      = 8'hC2;
    localparam logic [7:0] OP_JMP      = 8'hC3;
    localparam logic [7:0] OP_PUSH_B   = 8'hC5;
    localparam logic [7:0] OP_ADI      = 8'hC6;
    localparam logic [7:0] OP_RET      = 8'hC9;
    localparam logic [7:0] OP_CALL     = 8'hCD;
    localparam logic [7:0] OP_POP_D    = 8'hD1;
    localparam logic [7:0] OP_OUT      = 8'hD3;
    localparam logic [7:0] OP_PUSH_D   = 8'hD5;
    localparam logic [7:0] OP_POP_H    = 8'hE1;
    localparam logic [7:0] OP_PUSH_H   = 8'hE5;
    localparam logic [7:0] OP_ANI      = 8'hE6;
    localparam logic [7:0] OP_XCHG     = 8'hEB;
    localparam logic [7:0] OP_POP_PSW  = 8'hF1;
    localparam logic [7:0] OP_PUSH_PSW = 8'hF5;
    localparam logic [7:0] OP_EI       = 8'hFB;
    localparam logic [7:0] OP_CPI      = 8'hFE;
    localparam logic [7:0] PSW_ONE     = 8'h02;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_FETCH0,
        ST_FETCH1,
        ST_FETCH2,
        ST_GET2,
        ST_EXEC,
        ST_DATA,
        ST_GETD,
        ST_DATA2,
        ST_GETD2,
        ST_DONE
    } state_t;

    // Memory request from the sequencer to the RAM.
    typedef struct packed {
        logic        we;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } mem_req_t;

    function automatic logic even_parity(input logic [7:0] v);
        return ~(^v);
    endfunction

endpackage

`default_nettype wire

[hdl/ecpu_ram.sv]
// ----------------------------------------------------------------------------
// ecpu_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

[hdl/ecpu_alu.sv]
// ----------------------------------------------------------------------------
// ecpu_alu
// Shared 16-bit adder with flag logic for the CPU sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecpu_alu (
    input  wire logic [15:0] op_a,
    input  wire logic [15:0] op_b,
    input  wire logic        carry_in,
    output logic [16:0]      sum,
    output logic             parity_lo,
    output logic             zero_lo,
    output logic             sign_lo
);

    always_comb begin
        sum       = {1'b0, op_a} + {1'b0, op_b} + {16'd0, carry_in};
        parity_lo = ecpu_pkg::even_parity(sum[7:0]);
        zero_lo   = (sum[7:0] == 8'd0);
        sign_lo   = sum[7];
    end

endmodule

`default_nettype wire

[hdl/eight_bit_cpu_instruction_step.sv]
// ----------------------------------------------------------------------------
// eight_bit_cpu_instruction_step
// 8080-style CPU subset with internal byte memory, one instruction per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis: tdata = {load_data, load_address}, tuser = operation.
//   operation 0 writes one memory byte; operation 1 executes one instruction.
//   Master channel m_axis: one beat per input beat with the full register set.
//   A load writes its byte in ST_LOAD; an instruction runs ST_FETCH0 to ST_EXEC
//   and then any data states, set by the single memory port: up to three
//   fetch reads and two data accesses, each read returned by the registered RAM.
//   One beat is processed at a time; s_tready is low while busy.
//   After reset a clearing pass writes zero to all 2^ADDR_BITS bytes, one
//   byte a cycle, before the first beat is accepted.
//   Registers, SP, PC and flags reset to zero.
//   A stalled result holds in the CPU registers until m_tready; no new
//   beat is accepted meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "eight_bit_cpu_instruction_step_defines.svh"

module eight_bit_cpu_instruction_step #(
    parameter int ADDR_BITS = ecpu_pkg::ADDR_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [15:0] load_address, [23:16] load_data
    input  wire logic [23:0]  s_tdata,
    // [0] operation
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [7:0] acc, [15:8] reg_b, [23:16] reg_c, [31:24] reg_d, [39:32] reg_e,
    // [47:40] reg_h, [55:48] reg_l, [71:56] stack_pointer,
    // [87:72] program_counter, [92:88] flag_bits, [93] unknown_opcode, rest 0
    output logic [95:0]       m_tdata
);

    localparam int DEPTH = 1 << ADDR_BITS;

    ecpu_pkg::state_t state_reg, state_next;
    ecpu_pkg::mem_req_t req;
    logic [7:0] rdata;

    logic [7:0]  a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic [7:0]  e_reg, e_next, h_reg, h_next, l_reg, l_next;
    logic [15:0] sp_reg, sp_next, pc_reg, pc_next;
    logic [4:0]  f_reg, f_next;
    logic        unk_reg, unk_next;
    logic [7:0]  op_reg, op_next, b1_reg, b1_next, b2_reg, b2_next, t_reg, t_next;
    logic [ADDR_BITS-1:0] clr_reg, clr_next;
    logic [15:0] ld_addr_reg, ld_addr_next;
    logic [7:0]  ld_data_reg, ld_data_next;

    logic [15:0] alu_a, alu_b;
    logic        alu_ci;
    logic [16:0] alu_sum;
    logic        alu_p, alu_z, alu_s;

    logic [15:0] adr, hl, de, bc;
    logic        need2, need1, is_rd, is_rd2, is_wr, is_wr2;
    logic [7:0]  psw;

    assign adr = {b2_reg, b1_reg};
    assign hl  = {h_reg, l_reg};
    assign de  = {d_reg, e_reg};
    assign bc  = {b_reg, c_reg};
    assign psw = ecpu_pkg::PSW_ONE | {f_reg[4], f_reg[3], 1'b0, f_reg[2], 1'b0,
                                      f_reg[1], 1'b0, f_reg[0]};

    ecpu_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .aclk (aclk),
        .we   (req.we),
        .addr (req.addr[ADDR_BITS-1:0]),
        .wdata(req.wdata),
        .rdata(rdata)
    );

    ecpu_alu u_alu (
        .op_a     (alu_a),
        .op_b     (alu_b),
        .carry_in (alu_ci),
        .sum      (alu_sum),
        .parity_lo(alu_p),
        .zero_lo  (alu_z),
        .sign_lo  (alu_s)
    );

    // Opcode classes by operand length and memory use.
    always_comb begin
        need2 = 1'b0;
        need1 = 1'b0;
        unique case (op_reg) inside
            ecpu_pkg::OP_LXI_B, ecpu_pkg::OP_LXI_D, ecpu_pkg::OP_LXI_H,
            ecpu_pkg::OP_LXI_SP, ecpu_pkg::OP_STA, ecpu_pkg::OP_LDA,
            ecpu_pkg::OP_JNZ, ecpu_pkg::OP_JMP, ecpu_pkg::OP_CALL: need2 = 1'b1;
            ecpu_pkg::OP_MVI_B, ecpu_pkg::OP_MVI_C, ecpu_pkg::OP_MVI_H,
            ecpu_pkg::OP_MVI_M, ecpu_pkg::OP_MVI_A, ecpu_pkg::OP_ADI,
            ecpu_pkg::OP_ANI, ecpu_pkg::OP_CPI, ecpu_pkg::OP_OUT: need1 = 1'b1;
            default: ;
        endcase
        is_rd  = op_reg inside {ecpu_pkg::OP_LDAX_D, ecpu_pkg::OP_LDA, ecpu_pkg::OP_MOV_DM,
                                ecpu_pkg::OP_MOV_EM, ecpu_pkg::OP_MOV_HM, ecpu_pkg::OP_MOV_AM,
                                ecpu_pkg::OP_ADD_M, ecpu_pkg::OP_POP_B, ecpu_pkg::OP_RET,
                                ecpu_pkg::OP_POP_D, ecpu_pkg::OP_POP_H,
                                ecpu_pkg::OP_POP_PSW};
        is_rd2 = op_reg inside {ecpu_pkg::OP_POP_B, ecpu_pkg::OP_RET, ecpu_pkg::OP_POP_D,
                                ecpu_pkg::OP_POP_H, ecpu_pkg::OP_POP_PSW};
        is_wr  = op_reg inside {ecpu_pkg::OP_STA, ecpu_pkg::OP_MVI_M, ecpu_pkg::OP_MOV_MA,
                                ecpu_pkg::OP_PUSH_B, ecpu_pkg::OP_CALL, ecpu_pkg::OP_PUSH_D,
                                ecpu_pkg::OP_PUSH_H, ecpu_pkg::OP_PUSH_PSW};
        is_wr2 = op_reg inside {ecpu_pkg::OP_PUSH_B, ecpu_pkg::OP_CALL, ecpu_pkg::OP_PUSH_D,
                                ecpu_pkg::OP_PUSH_H, ecpu_pkg::OP_PUSH_PSW};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ecpu_pkg::ST_CLEAR;
            clr_reg   <= '0;
            a_reg <= '0; b_reg <= '0; c_reg <= '0; d_reg <= '0;
            e_reg <= '0; h_reg <= '0; l_reg <= '0;
            sp_reg <= '0; pc_reg <= '0; f_reg <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            a_reg <= a_next; b_reg <= b_next; c_reg <= c_next; d_reg <= d_next;
            e_reg <= e_next; h_reg <= h_next; l_reg <= l_next;
            sp_reg <= sp_next; pc_reg <= pc_next; f_reg <= f_next;
        end
        unk_reg     <= unk_next;
        op_reg      <= op_next;
        b1_reg      <= b1_next;
        b2_reg      <= b2_next;
        t_reg       <= t_next;
        ld_addr_reg <= ld_addr_next;
        ld_data_reg <= ld_data_next;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        unique case (state_reg)
            ecpu_pkg::ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (&clr_reg) state_next = ecpu_pkg::ST_IDLE;
            end
            ecpu_pkg::ST_IDLE:
                if (s_tvalid) begin
                    state_next = s_tuser ? ecpu_pkg::ST_FETCH0 : ecpu_pkg::ST_LOAD;
                end
            ecpu_pkg::ST_LOAD:   state_next = ecpu_pkg::ST_DONE;
            ecpu_pkg::ST_FETCH0: state_next = ecpu_pkg::ST_FETCH1;
            ecpu_pkg::ST_FETCH1: state_next = ecpu_pkg::ST_FETCH2;
            ecpu_pkg::ST_FETCH2: state_next = ecpu_pkg::ST_GET2;
            ecpu_pkg::ST_GET2:   state_next = ecpu_pkg::ST_EXEC;
            ecpu_pkg::ST_EXEC:
                if (is_rd || is_wr) state_next = ecpu_pkg::ST_DATA;
                else state_next = ecpu_pkg::ST_DONE;
            ecpu_pkg::ST_DATA:
                if (is_rd) state_next = ecpu_pkg::ST_GETD;
                else if (is_wr2) state_next = ecpu_pkg::ST_DATA2;
                else state_next = ecpu_pkg::ST_DONE;
            ecpu_pkg::ST_GETD:
                if (is_rd2) state_next = ecpu_pkg::ST_DATA2;
                else state_next = ecpu_pkg::ST_DONE;
            ecpu_pkg::ST_DATA2:
                if (is_rd2) state_next = ecpu_pkg::ST_GETD2;
                else state_next = ecpu_pkg::ST_DONE;
            ecpu_pkg::ST_GETD2: state_next = ecpu_pkg::ST_DONE;
            ecpu_pkg::ST_DONE:
                if (m_tready) state_next = ecpu_pkg::ST_IDLE;
            default: state_next = ecpu_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory requests.
    always_comb begin
        a_next = a_reg; b_next = b_reg; c_next = c_reg; d_next = d_reg;
        e_next = e_reg; h_next = h_reg; l_next = l_reg;
        sp_next = sp_reg; pc_next = pc_reg; f_next = f_reg;
        unk_next = unk_reg; op_next = op_reg; b1_next = b1_reg; b2_next = b2_reg;
        t_next = t_reg;
        ld_addr_next = ld_addr_reg; ld_data_next = ld_data_reg;
        req = '{we: 1'b0, addr: pc_reg, wdata: 8'd0};
        alu_a = 16'd0; alu_b = 16'd0; alu_ci = 1'b0;
        unique case (state_reg)
            ecpu_pkg::ST_CLEAR: begin
                req.we   = 1'b1;
                req.addr = 16'(clr_reg);
            end
            ecpu_pkg::ST_IDLE: begin
                ld_addr_next = s_tdata[15:0];
                ld_data_next = s_tdata[23:16];
                unk_next     = 1'b0;
            end
            ecpu_pkg::ST_LOAD: begin
                req = '{we: 1'b1, addr: ld_addr_reg, wdata: ld_data_reg};
            end
            ecpu_pkg::ST_FETCH0: begin
                alu_a = pc_reg; alu_b = 16'd1;
                req.addr = pc_reg;
            end
            ecpu_pkg::ST_FETCH1: begin
                alu_a = pc_reg; alu_b = 16'd1;
                req.addr = alu_sum[15:0];
                op_next = rdata;
            end
            ecpu_pkg::ST_FETCH2: begin
                alu_a = pc_reg; alu_b = 16'd2;
                req.addr = alu_sum[15:0];
                b1_next = rdata;
            end
            ecpu_pkg::ST_GET2: b2_next = rdata;
            ecpu_pkg::ST_EXEC: begin
                alu_a = pc_reg;
                alu_b = need2 ? 16'd3 : (need1 ? 16'd2 : 16'd1);
                pc_next = alu_sum[15:0];
                unique case (op_reg) inside
                    ecpu_pkg::OP_NOP, ecpu_pkg::OP_EI, ecpu_pkg::OP_OUT: ;
                    ecpu_pkg::OP_LXI_B: begin c_next = b1_reg; b_next = b2_reg; end
                    ecpu_pkg::OP_LXI_D: begin e_next = b1_reg; d_next = b2_reg; end
                    ecpu_pkg::OP_LXI_H: begin l_next = b1_reg; h_next = b2_reg; end
                    ecpu_pkg::OP_LXI_SP: sp_next = adr;
                    ecpu_pkg::OP_MVI_B: b_next = b1_reg;
                    ecpu_pkg::OP_MVI_C: c_next = b1_reg;
                    ecpu_pkg::OP_MVI_H: h_next = b1_reg;
                    ecpu_pkg::OP_MVI_A: a_next = b1_reg;
                    ecpu_pkg::OP_DCR_B, ecpu_pkg::OP_DCR_C: begin
                        alu_a = {8'd0, (op_reg == ecpu_pkg::OP_DCR_B) ? b_reg : c_reg};
                        alu_b = 16'h00FF;
                        if (op_reg == ecpu_pkg::OP_DCR_B) b_next = alu_sum[7:0];
                        else c_next = alu_sum[7:0];
                        pc_next = pc_reg + 16'd1;
                        f_next = {alu_s, alu_z, f_reg[2], alu_p, f_reg[0]};
                    end
                    ecpu_pkg::OP_DAD_B, ecpu_pkg::OP_DAD_D, ecpu_pkg::OP_DAD_H: begin
                        alu_a = hl;
                        alu_b = (op_reg == ecpu_pkg::OP_DAD_B) ? bc
                              : ((op_reg == ecpu_pkg::OP_DAD_D) ? de : hl);
                        h_next = alu_sum[15:8]; l_next = alu_sum[7:0];
                        f_next[0] = alu_sum[16];
                        pc_next = pc_reg + 16'd1;
                    end
                    ecpu_pkg::OP_INX_D, ecpu_pkg::OP_INX_H: begin
                        alu_a = (op_reg == ecpu_pkg::OP_INX_D) ? de : hl; alu_b = 16'd1;
                        if (op_reg == ecpu_pkg::OP_INX_D) begin
                            d_next = alu_sum[15:8]; e_next = alu_sum[7:0];
                        end else begin
                            h_next = alu_sum[15:8]; l_next = alu_sum[7:0];
                        end
                        pc_next = pc_reg + 16'd1;
                    end
                    ecpu_pkg::OP_RRC: begin
                        a_next = {a_reg[0], a_reg[7:1]}; f_next[0] = a_reg[0];
                    end
                    ecpu_pkg::OP_RAR: begin
                        a_next = {f_reg[0], a_reg[7:1]}; f_next[0] = a_reg[0];
                    end
                    ecpu_pkg::OP_CMA: a_next = ~a_reg;
                    ecpu_pkg::OP_MOV_BC: b_next = c_reg;
                    ecpu_pkg::OP_MOV_BD: b_next = d_reg;
                    ecpu_pkg::OP_MOV_BE: b_next = e_reg;
                    ecpu_pkg::OP_MOV_LA: l_next = a_reg;
                    ecpu_pkg::OP_MOV_AD: a_next = d_reg;
                    ecpu_pkg::OP_MOV_AE: a_next = e_reg;
                    ecpu_pkg::OP_MOV_AH: a_next = h_reg;
                    ecpu_pkg::OP_ADD_B, ecpu_pkg::OP_ADD_C, ecpu_pkg::OP_ADI: begin
                        alu_a = {8'd0, a_reg};
                        alu_b = {8'd0, (op_reg == ecpu_pkg::OP_ADD_B) ? b_reg
                                : ((op_reg == ecpu_pkg::OP_ADD_C) ? c_reg : b1_reg)};
                        a_next = alu_sum[7:0];
                        f_next = {alu_s, alu_z, f_reg[2], alu_p, alu_sum[8]};
                        pc_next = pc_reg + ((op_reg == ecpu_pkg::OP_ADI) ? 16'd2 : 16'd1);
                    end
                    ecpu_pkg::OP_ANA_A, ecpu_pkg::OP_XRA_A, ecpu_pkg::OP_ANI: begin
                        alu_a = {8'd0, (op_reg == ecpu_pkg::OP_XRA_A) ? 8'd0
                                : ((op_reg == ecpu_pkg::OP_ANI) ? (a_reg & b1_reg) : a_reg)};
                        alu_b = 16'd0;
                        a_next = alu_sum[7:0];
                        f_next = {alu_s, alu_z,
                                  (op_reg == ecpu_pkg::OP_ANI) ? f_reg[2] : 1'b0,
                                  alu_p, 1'b0};
                        pc_next = pc_reg + ((op_reg == ecpu_pkg::OP_ANI) ? 16'd2 : 16'd1);
                    end
                    ecpu_pkg::OP_CPI: begin
                        alu_a = {8'd0, a_reg}; alu_b = {8'd0, ~b1_reg}; alu_ci = 1'b1;
                        f_next = {alu_s, alu_z, f_reg[2], alu_p, ~alu_sum[8]};
                        pc_next = pc_reg + 16'd2;
                    end
                    ecpu_pkg::OP_JNZ: if (!f_reg[3]) pc_next = adr;
                    ecpu_pkg::OP_JMP: pc_next = adr;
                    ecpu_pkg::OP_CALL: t_next = alu_sum[15:8];
                    ecpu_pkg::OP_XCHG: begin
                        h_next = d_reg; d_next = h_reg; l_next = e_reg; e_next = l_reg;
                    end
                    ecpu_pkg::OP_LDAX_D, ecpu_pkg::OP_STA, ecpu_pkg::OP_MVI_M,
                    ecpu_pkg::OP_LDA, ecpu_pkg::OP_MOV_DM, ecpu_pkg::OP_MOV_EM,
                    ecpu_pkg::OP_MOV_HM, ecpu_pkg::OP_MOV_MA, ecpu_pkg::OP_MOV_AM,
                    ecpu_pkg::OP_ADD_M, ecpu_pkg::OP_POP_B, ecpu_pkg::OP_PUSH_B,
                    ecpu_pkg::OP_RET, ecpu_pkg::OP_POP_D, ecpu_pkg::OP_PUSH_D,
                    ecpu_pkg::OP_POP_H, ecpu_pkg::OP_PUSH_H, ecpu_pkg::OP_POP_PSW,
                    ecpu_pkg::OP_PUSH_PSW: ;
                    default: begin
                        unk_next = 1'b1;
                        pc_next  = pc_reg + 16'd1;
                    end
                endcase
            end
            ecpu_pkg::ST_DATA: begin
                // First data access; stack writes go to SP-1 (high byte).
                alu_a = sp_reg;
                alu_b = is_rd2 ? 16'd0 : 16'hFFFF;
                unique case (op_reg) inside
                    ecpu_pkg::OP_LDAX_D: req.addr = de;
                    ecpu_pkg::OP_LDA: req.addr = adr;
                    ecpu_pkg::OP_STA: req = '{we: 1'b1, addr: adr, wdata: a_reg};
                    ecpu_pkg::OP_MVI_M: req = '{we: 1'b1, addr: hl, wdata: b1_reg};
                    ecpu_pkg::OP_MOV_MA: req = '{we: 1'b1, addr: hl, wdata: a_reg};
                    ecpu_pkg::OP_PUSH_B:
                        req = '{we: 1'b1, addr: alu_sum[15:0], wdata: b_reg};
                    ecpu_pkg::OP_PUSH_D:
                        req = '{we: 1'b1, addr: alu_sum[15:0], wdata: d_reg};
                    ecpu_pkg::OP_PUSH_H:
                        req = '{we: 1'b1, addr: alu_sum[15:0], wdata: h_reg};
                    ecpu_pkg::OP_PUSH_PSW:
                        req = '{we: 1'b1, addr: alu_sum[15:0], wdata: a_reg};
                    ecpu_pkg::OP_CALL:
                        req = '{we: 1'b1, addr: alu_sum[15:0], wdata: t_reg};
                    ecpu_pkg::OP_POP_B, ecpu_pkg::OP_RET, ecpu_pkg::OP_POP_D,
                    ecpu_pkg::OP_POP_H, ecpu_pkg::OP_POP_PSW: req.addr = sp_reg;
                    default: req.addr = hl;
                endcase
            end
            ecpu_pkg::ST_GETD: begin
                unique case (op_reg) inside
                    ecpu_pkg::OP_MOV_DM: d_next = rdata;
                    ecpu_pkg::OP_MOV_EM: e_next = rdata;
                    ecpu_pkg::OP_MOV_HM: h_next = rdata;
                    ecpu_pkg::OP_ADD_M: begin
                        alu_a = {8'd0, a_reg}; alu_b = {8'd0, rdata};
                        a_next = alu_sum[7:0];
                        f_next = {alu_s, alu_z, f_reg[2], alu_p, alu_sum[8]};
                    end
                    ecpu_pkg::OP_LDAX_D, ecpu_pkg::OP_LDA, ecpu_pkg::OP_MOV_AM:
                        a_next = rdata;
                    default: t_next = rdata;
                endcase
            end
            ecpu_pkg::ST_DATA2: begin
                if (is_rd2) begin
                    alu_a = sp_reg; alu_b = 16'd1;
                    req.addr = alu_sum[15:0];
                end else begin
                    alu_a = sp_reg; alu_b = 16'hFFFE;
                    req.we = 1'b1; req.addr = alu_sum[15:0];
                    sp_next = alu_sum[15:0];
                    unique case (op_reg)
                        ecpu_pkg::OP_PUSH_B: req.wdata = c_reg;
                        ecpu_pkg::OP_PUSH_D: req.wdata = e_reg;
                        ecpu_pkg::OP_PUSH_H: req.wdata = l_reg;
                        ecpu_pkg::OP_PUSH_PSW: req.wdata = psw;
                        default: begin
                            // Return address low byte, then jump.
                            req.wdata = pc_reg[7:0];
                            pc_next = adr;
                        end
                    endcase
                end
            end
            ecpu_pkg::ST_GETD2: begin
                alu_a = sp_reg; alu_b = 16'd2;
                sp_next = alu_sum[15:0];
                unique case (op_reg)
                    ecpu_pkg::OP_POP_B: begin b_next = rdata; c_next = t_reg; end
                    ecpu_pkg::OP_POP_D: begin d_next = rdata; e_next = t_reg; end
                    ecpu_pkg::OP_POP_H: begin h_next = rdata; l_next = t_reg; end
                    ecpu_pkg::OP_RET: pc_next = {rdata, t_reg};
                    default: begin
                        a_next = rdata;
                        f_next = {t_reg[7], t_reg[6], t_reg[4], t_reg[2], t_reg[0]};
                    end
                endcase
            end
            ecpu_pkg::ST_DONE: ;
            default: ;
        endcase
    end

    // Outputs.
    always_comb begin
        s_tready = (state_reg == ecpu_pkg::ST_IDLE);
        m_tvalid = (state_reg == ecpu_pkg::ST_DONE);
        m_tdata  = {2'b00, unk_reg, f_reg, pc_reg, sp_reg,
                    l_reg, h_reg, e_reg, d_reg, c_reg, b_reg, a_reg};
    end

    `ECPU_ASSERT_IMP(a_valid_done, aclk, aresetn, m_tvalid,
        state_reg == ecpu_pkg::ST_DONE, "result shown outside done")
    `ECPU_ASSERT_IMP(a_excl, aclk, aresetn, s_tready, !m_tvalid,
        "ready while result pending")
    `ECPU_ASSERT_NEXT(a_start, aclk, aresetn, s_tvalid && s_tready, !s_tready,
        "block took a second beat while busy")
    `ECPU_ASSERT_NEXT(a_ld_unk, aclk, aresetn,
        state_reg == ecpu_pkg::ST_LOAD, !unk_reg, "load flagged unknown opcode")

endmodule

`default_nettype wire
